@@ design/fdf_pkg.sv @@
// ----------------------------------------------------------------------------
// fdf_pkg
// Types and constants shared by the FLV tag deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fdf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned KIND_W  = 2;

  localparam logic [BYTE_W-1:0] SIG_0 = 8'h46;  // 'F'
  localparam logic [BYTE_W-1:0] SIG_1 = 8'h4C;  // 'L'
  localparam logic [BYTE_W-1:0] SIG_2 = 8'h56;  // 'V'

  localparam int unsigned SIG_BYTES       = 3;
  localparam int unsigned FILE_HDR_BYTES  = 3 + 1 + 1 + 4 + 4;
  localparam int unsigned TAG_HDR_BYTES   = 11;
  localparam int unsigned PREV_SIZE_BYTES = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_BAD_SIG = 2'd2
  } kind_e;

  typedef enum logic [5:0] {
    PH_SIG     = 6'b000001,
    PH_FHDR    = 6'b000010,
    PH_TAGHDR  = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_PREV    = 6'b010000,
    PH_DEAD    = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              start_of_file;
  } item_t;

  typedef struct packed {
    kind_e             result_kind;
    logic [BYTE_W-1:0] tag_type;
    logic [LEN_W-1:0]  payload_length;
    logic [TS_W-1:0]   tag_timestamp;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_byte;
  } result_t;

endpackage

`default_nettype wire

@@ design/fdf_if.sv @@
// ----------------------------------------------------------------------------
// fdf_if
// Valid/ready channels for the byte input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdf_in_if;
  logic                          valid;
  logic                          ready;
  logic [fdf_pkg::BYTE_W-1:0]    data_byte;
  logic                          start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface fdf_out_if;
  logic                          valid;
  logic                          ready;
  logic [fdf_pkg::KIND_W-1:0]    result_kind;
  logic [fdf_pkg::BYTE_W-1:0]    tag_type;
  logic [fdf_pkg::LEN_W-1:0]     payload_length;
  logic [fdf_pkg::TS_W-1:0]      tag_timestamp;
  logic [fdf_pkg::BYTE_W-1:0]    payload_byte;
  logic                          last_byte;

  modport source (output valid, output result_kind, output tag_type, output payload_length,
                  output tag_timestamp, output payload_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input result_kind, input tag_type, input payload_length,
                  input tag_timestamp, input payload_byte, input last_byte,
                  output ready);
endinterface

`default_nettype wire

@@ design/fdf_in_stage.sv @@
// ----------------------------------------------------------------------------
// fdf_in_stage
// Input register: holds one byte item until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fdf_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire fdf_pkg::item_t item_i,
  output logic                valid_o,
  input  wire logic           take_i,
  output fdf_pkg::item_t      item_o
);

  logic           valid_q;
  fdf_pkg::item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ design/fdf_parser.sv @@
// ----------------------------------------------------------------------------
// fdf_parser
// FLV parse state and per-byte result logic; state moves when an item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fdf_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire fdf_pkg::item_t   item_i,
  output logic                  res_valid_o,
  output fdf_pkg::result_t      res_o
);

  fdf_pkg::phase_e                phase_q, phase_d, phase;
  logic [fdf_pkg::LEN_W-1:0]      cnt_q, cnt_d, cnt;
  logic [fdf_pkg::BYTE_W-1:0]     type_q, type_d, type_h;
  logic [fdf_pkg::LEN_W-1:0]      len_q, len_d, len_h;
  logic [fdf_pkg::TS_W-1:0]       ts_q, ts_d, ts_h;
  logic [fdf_pkg::BYTE_W-1:0]     b;
  logic [fdf_pkg::BYTE_W-1:0]     want;
  logic [fdf_pkg::LEN_W:0]        cnt_inc;
  logic                           last;

  assign b       = item_i.data_byte;
  assign cnt_inc = {1'b0, cnt} + {{fdf_pkg::LEN_W{1'b0}}, 1'b1};
  assign last    = cnt_inc >= {1'b0, len_h};

  always_comb begin
    phase  = phase_q;
    cnt    = cnt_q;
    type_h = type_q;
    len_h  = len_q;
    ts_h   = ts_q;
    if (item_i.start_of_file) begin
      phase  = fdf_pkg::PH_SIG;
      cnt    = '0;
      type_h = '0;
      len_h  = '0;
      ts_h   = '0;
    end

    if (cnt == '0) begin
      want = fdf_pkg::SIG_0;
    end else if (cnt == fdf_pkg::LEN_W'(1)) begin
      want = fdf_pkg::SIG_1;
    end else begin
      want = fdf_pkg::SIG_2;
    end

    phase_d = phase;
    cnt_d   = cnt;
    type_d  = type_h;
    len_d   = len_h;
    ts_d    = ts_h;

    res_valid_o          = 1'b0;
    res_o.result_kind    = fdf_pkg::KIND_HEADER;
    res_o.tag_type       = type_h;
    res_o.payload_length = len_h;
    res_o.tag_timestamp  = ts_h;
    res_o.payload_byte   = '0;
    res_o.last_byte      = 1'b0;

    unique case (phase)
      fdf_pkg::PH_SIG: begin
        if (b != want) begin
          res_valid_o          = 1'b1;
          res_o.result_kind    = fdf_pkg::KIND_BAD_SIG;
          res_o.tag_type       = '0;
          res_o.payload_length = '0;
          res_o.tag_timestamp  = '0;
          phase_d              = fdf_pkg::PH_DEAD;
          cnt_d                = '0;
        end else if (cnt >= fdf_pkg::LEN_W'(fdf_pkg::SIG_BYTES - 1)) begin
          phase_d = fdf_pkg::PH_FHDR;
          cnt_d   = fdf_pkg::LEN_W'(fdf_pkg::SIG_BYTES);
        end else begin
          cnt_d = cnt_inc[fdf_pkg::LEN_W-1:0];
        end
      end
      fdf_pkg::PH_FHDR: begin
        if (cnt >= fdf_pkg::LEN_W'(fdf_pkg::FILE_HDR_BYTES - 1)) begin
          phase_d = fdf_pkg::PH_TAGHDR;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc[fdf_pkg::LEN_W-1:0];
        end
      end
      fdf_pkg::PH_TAGHDR: begin
        case (cnt)
          24'd0:   type_d        = b;
          24'd1:   len_d[23:16]  = b;
          24'd2:   len_d[15:8]   = b;
          24'd3:   len_d[7:0]    = b;
          24'd4:   ts_d[23:16]   = b;
          24'd5:   ts_d[15:8]    = b;
          24'd6:   ts_d[7:0]     = b;
          24'd7:   ts_d[31:24]   = b;
          default: ;
        endcase
        if (cnt >= fdf_pkg::LEN_W'(fdf_pkg::TAG_HDR_BYTES - 1)) begin
          res_valid_o       = 1'b1;
          res_o.result_kind = fdf_pkg::KIND_HEADER;
          phase_d           = (len_h == '0) ? fdf_pkg::PH_PREV : fdf_pkg::PH_PAYLOAD;
          cnt_d             = '0;
        end else begin
          cnt_d = cnt_inc[fdf_pkg::LEN_W-1:0];
        end
      end
      fdf_pkg::PH_PAYLOAD: begin
        res_valid_o        = 1'b1;
        res_o.result_kind  = fdf_pkg::KIND_PAYLOAD;
        res_o.payload_byte = b;
        res_o.last_byte    = last;
        if (last) begin
          phase_d = fdf_pkg::PH_PREV;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc[fdf_pkg::LEN_W-1:0];
        end
      end
      fdf_pkg::PH_PREV: begin
        if (cnt >= fdf_pkg::LEN_W'(fdf_pkg::PREV_SIZE_BYTES - 1)) begin
          phase_d = fdf_pkg::PH_TAGHDR;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc[fdf_pkg::LEN_W-1:0];
        end
      end
      fdf_pkg::PH_DEAD: begin
      end
      default: begin
        phase_d = fdf_pkg::PH_SIG;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fdf_pkg::PH_SIG;
      cnt_q   <= '0;
      type_q  <= '0;
      len_q   <= '0;
      ts_q    <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      type_q  <= type_d;
      len_q   <= len_d;
      ts_q    <= ts_d;
    end
  end

endmodule

`default_nettype wire

@@ design/fdf_out_stage.sv @@
// ----------------------------------------------------------------------------
// fdf_out_stage
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fdf_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire logic             res_valid_i,
  input  wire fdf_pkg::result_t res_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output fdf_pkg::result_t      res_o
);

  logic             valid_q;
  fdf_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

@@ design/flv_tag_deframer_unit.sv @@
// Accepted bytes pass the input register, then their result items the result register,
// which split the path; throughput is one byte per cycle unless the output stalls.
// Each byte gives at most one result item; stalls on the output back up the input.
// Reset: asynchronous, clears both stage valids and puts the parser at the FLV signature.
// ----------------------------------------------------------------------------
// flv_tag_deframer_unit
// FLV byte-stream deframer: checks the signature, reporting a mismatch, skips the file header,
// emits one header item per tag followed by its payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module flv_tag_deframer_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fdf_in_if.sink     in_i,
  fdf_out_if.source  out_o
);

  fdf_pkg::item_t   in_item;
  fdf_pkg::item_t   stage_item;
  fdf_pkg::result_t res;
  fdf_pkg::result_t out_res;
  logic             stage_valid;
  logic             out_free;
  logic             take;
  logic             res_valid;

  assign in_item.data_byte     = in_i.data_byte;
  assign in_item.start_of_file = in_i.start_of_file;
  assign take                  = stage_valid && out_free;

  fdf_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .take_i  (take),
    .item_o  (stage_item)
  );

  fdf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (stage_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fdf_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .res_o       (out_res)
  );

  assign out_o.result_kind    = out_res.result_kind;
  assign out_o.tag_type       = out_res.tag_type;
  assign out_o.payload_length = out_res.payload_length;
  assign out_o.tag_timestamp  = out_res.tag_timestamp;
  assign out_o.payload_byte   = out_res.payload_byte;
  assign out_o.last_byte      = out_res.last_byte;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for flv_tag_deframer_unit. A directed byte table covers
// signature errors, the file header and one tag at its field extremes. Random
// FLV files follow, mostly well formed with random content, plus truncated
// files, broken signatures and stray bytes. A behavioral parser predicts every
// random-file item; both channels idle at random and the receiver stalls once long.
// ----------------------------------------------------------------------------
module tb;
  import fdf_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              sof;
    bit                fixed;
    result_t           res;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;

  fdf_in_if  in_if ();
  fdf_out_if out_if ();

  flv_tag_deframer_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk = ~clk;

  // parser state
  phase_e            phase;
  logic [LEN_W-1:0]  pos;
  logic [BYTE_W-1:0] held_type;
  logic [LEN_W-1:0]  held_len;
  logic [TS_W-1:0]   held_ts;

  result_t pending_results[$];
  step_t   plan[$];
  int      mismatches = 0;
  int      items_taken = 0;
  int      results_seen = 0;
  bit      calm = 1'b0;

  function automatic void restart_parser();
    phase     = PH_SIG;
    pos       = '0;
    held_type = '0;
    held_len  = '0;
    held_ts   = '0;
  endfunction

  function automatic result_t mk_res(kind_e k, logic [BYTE_W-1:0] t, logic [LEN_W-1:0] l,
                                     logic [TS_W-1:0] ts, logic [BYTE_W-1:0] pb, logic lb);
    result_t r;
    r.result_kind    = k;
    r.tag_type       = t;
    r.payload_length = l;
    r.tag_timestamp  = ts;
    r.payload_byte   = pb;
    r.last_byte      = lb;
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic void add_step(logic [BYTE_W-1:0] d, logic s, bit f = 1'b0,
                                   result_t r = '0);
    step_t st;
    st.data  = d;
    st.sof   = s;
    st.fixed = f;
    st.res   = r;
    plan.push_back(st);
  endfunction

  task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic s,
                              output bit got, output result_t r);
    logic [BYTE_W-1:0] sig_want;
    bit                last;
    got = 1'b0;
    r   = '0;
    if (s) restart_parser();
    case (phase)
      PH_SIG: begin
        sig_want = (pos == 0) ? SIG_0 : (pos == 1) ? SIG_1 : SIG_2;
        if (b != sig_want) begin
          r.result_kind = KIND_BAD_SIG;
          got   = 1'b1;
          phase = PH_DEAD;
          pos   = '0;
        end else if (pos >= SIG_BYTES - 1) begin
          phase = PH_FHDR;
          pos   = LEN_W'(SIG_BYTES);
        end else begin
          pos++;
        end
      end
      PH_FHDR: begin
        if (32'(pos) + 1 >= FILE_HDR_BYTES) begin
          phase = PH_TAGHDR;
          pos   = '0;
        end else begin
          pos++;
        end
      end
      PH_TAGHDR: begin
        case (pos)
          0: held_type       = b;
          1: held_len[23:16] = b;
          2: held_len[15:8]  = b;
          3: held_len[7:0]   = b;
          4: held_ts[23:16]  = b;
          5: held_ts[15:8]   = b;
          6: held_ts[7:0]    = b;
          7: held_ts[31:24]  = b;
          default: ;
        endcase
        if (32'(pos) + 1 >= TAG_HDR_BYTES) begin
          r   = mk_res(KIND_HEADER, held_type, held_len, held_ts, '0, 1'b0);
          got = 1'b1;
          phase = (held_len == 0) ? PH_PREV : PH_PAYLOAD;
          pos   = '0;
        end else begin
          pos++;
        end
      end
      PH_PAYLOAD: begin
        last = (32'(pos) + 1 >= 32'(held_len));
        r    = mk_res(KIND_PAYLOAD, held_type, held_len, held_ts, b, last);
        got  = 1'b1;
        if (last) begin
          phase = PH_PREV;
          pos   = '0;
        end else begin
          pos++;
        end
      end
      PH_PREV: begin
        if (32'(pos) + 1 >= PREV_SIZE_BYTES) begin
          phase = PH_TAGHDR;
          pos   = '0;
        end else begin
          pos++;
        end
      end
      default: ;
    endcase
  endtask

  // called at a rising edge; returns at the edge where the byte is taken
  task automatic offer_byte(input logic [BYTE_W-1:0] d, input logic s,
                            input bit fixed = 1'b0, input result_t fixed_res = '0);
    bit      got;
    bit      ignored;
    result_t r;
    while (!calm && $urandom_range(0, 99) < 16) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= d;
    in_if.start_of_file <= s;
    do @(posedge clk); while (!in_if.ready);
    ignored = (phase == PH_DEAD) && !s;
    deframe_byte(d, s, got, r);
    if (fixed) pending_results.push_back(fixed_res);
    else if (got) pending_results.push_back(r);
    if (!ignored) begin
      items_taken++;
      calm = (items_taken >= 700) && (items_taken < 1000);
    end
  endtask

  task automatic offer_random_file();
    int                roll;
    int                bad_at;
    int                ntags;
    int                cut_tag;
    int                len;
    int                nsend;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sig [3];
    sig[0] = SIG_0;
    sig[1] = SIG_1;
    sig[2] = SIG_2;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 6)) offer_byte(rand_byte(), $urandom_range(0, 3) == 0);
      return;
    end
    bad_at = (roll < 18) ? $urandom_range(0, 2) : 3;
    for (int i = 0; i < 3; i++) begin
      b = sig[i];
      if (i == bad_at) b = sig[i] ^ BYTE_W'($urandom_range(1, 255));
      offer_byte(b, i == 0);
      if (i == bad_at) begin
        repeat ($urandom_range(0, 5)) offer_byte(rand_byte(), 1'b0);
        return;
      end
    end
    repeat (FILE_HDR_BYTES - SIG_BYTES) offer_byte(rand_byte(), 1'b0);
    ntags   = $urandom_range(1, 5);
    cut_tag = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ntags - 1) : ntags;
    for (int t = 0; t < ntags; t++) begin
      if (t == cut_tag) begin
        repeat ($urandom_range(1, TAG_HDR_BYTES - 1)) offer_byte(rand_byte(), 1'b0);
        return;
      end
      roll = $urandom_range(0, 99);
      len  = (roll < 10) ? 0 :
             (roll < 80) ? $urandom_range(1, 16) :
             (roll < 94) ? $urandom_range(17, 64) : $urandom_range(65, 24'hFFFFFF);
      roll = $urandom_range(0, 3);
      b    = (roll == 0) ? 8'd8 : (roll == 1) ? 8'd9 : (roll == 2) ? 8'd18 : rand_byte();
      offer_byte(b, 1'b0);
      offer_byte(len[23:16], 1'b0);
      offer_byte(len[15:8], 1'b0);
      offer_byte(len[7:0], 1'b0);
      repeat (TAG_HDR_BYTES - 4) offer_byte(rand_byte(), 1'b0);
      // huge tags are abandoned after a few bytes
      nsend = (len > 64) ? $urandom_range(1, 20) : len;
      repeat (nsend) offer_byte(rand_byte(), 1'b0);
      if (nsend < len) return;
      repeat (PREV_SIZE_BYTES) offer_byte(rand_byte(), 1'b0);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
    end
  endfunction

  // result side
  initial begin
    result_t want;
    int      hold_left;
    bit      hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got kind %0d", $time,
                   out_if.result_kind);
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", want.result_kind, out_if.result_kind);
          check_field("tag_type", want.tag_type, out_if.tag_type);
          check_field("payload_length", want.payload_length, out_if.payload_length);
          check_field("tag_timestamp", want.tag_timestamp, out_if.tag_timestamp);
          check_field("payload_byte", want.payload_byte, out_if.payload_byte);
          check_field("last_byte", want.last_byte, out_if.last_byte);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= 400) begin
        hold_done = 1'b1;
        hold_left = 300;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  // byte side
  initial begin
    logic [BYTE_W-1:0] file_head [13];
    logic [BYTE_W-1:0] tag_head [10];
    result_t           bad_sig;
    file_head = '{SIG_0, SIG_1, SIG_2, 8'hFF, 8'h05, 8'h00, 8'h00, 8'h00, 8'h09,
                  8'h00, 8'h00, 8'h00, 8'h00};
    tag_head  = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
    bad_sig   = mk_res(KIND_BAD_SIG, '0, '0, '0, '0, 1'b0);
    restart_parser();
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.data_byte     <= '0;
    in_if.start_of_file <= 1'b0;

    add_step(8'h00, 1'b0, 1'b1, bad_sig);  // no start mark, wrong first byte
    add_step(SIG_0, 1'b1);
    add_step(8'h00, 1'b0, 1'b1, bad_sig);  // breaks on the second byte
    foreach (file_head[i]) add_step(file_head[i], i == 0);
    foreach (tag_head[i]) add_step(tag_head[i], 1'b0);
    add_step(8'h00, 1'b0, 1'b1, mk_res(KIND_HEADER, 8'hFF, 24'h000001, 32'hFFFF_FFFF,
                                       8'h00, 1'b0));
    add_step(8'h00, 1'b0, 1'b1, mk_res(KIND_PAYLOAD, 8'hFF, 24'h000001, 32'hFFFF_FFFF,
                                       8'h00, 1'b1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) offer_byte(plan[i].data, plan[i].sof, plan[i].fixed, plan[i].res);
    items_taken = 0;
    while (items_taken < 1900) offer_random_file();
    in_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
design/fdf_pkg.sv
design/fdf_if.sv
design/fdf_in_stage.sv
design/fdf_parser.sv
design/fdf_out_stage.sv
design/flv_tag_deframer_unit.sv
sim/tb.sv
